FILE: rtl/btlv_pkg.sv
// Types and constants for the BER tag-length-value element parser.
// No dependencies. Imported by ber_tlv_element_parser.
`timescale 1ns / 1ps

package btlv_pkg;

    typedef enum logic [4:0] {
        PH_TAG       = 5'b00001,
        PH_LEN_FIRST = 5'b00010,
        PH_LEN_LONG  = 5'b00100,
        PH_CONTENT   = 5'b01000,
        PH_DROP      = 5'b10000
    } t_phase;

    localparam logic [1:0] MODE_INT = 2'd0;
    localparam logic [1:0] MODE_OCT = 2'd1;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic [7:0] TAG_INTEGER = 8'h02;
    localparam logic [7:0] TAG_OCTETS  = 8'h04;
    localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
    localparam logic [6:0] LEN_COUNT_MASK = 7'h7F;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value_byte;
        logic [7:0]  element_tag;
        logic [31:0] element_length;
        logic [63:0] integer_value;
        logic [1:0]  status;
    } t_result;

endpackage

FILE: rtl/ber_tlv_element_parser.sv
// BER tag-length-value element parser, top level.
// Depends on btlv_pkg for phase codes, result codes and the result record.
`timescale 1ns / 1ps

// Takes one encoded byte per request and parses one BER element per run:
// tag, short or long form length (up to MAX_LENGTH_BYTES length bytes), then
// content as integer, octet string or skipped bytes, with mode sampled on the
// tag byte. tlast marks the last byte of the buffer. Each byte gives at most
// one result: a content byte, an element-complete record or an error
// (truncated or malformed); after an error, bytes are dropped through the
// buffer end. One byte is accepted every cycle while the result side takes
// results; each byte passes an input register and the parse logic into the
// result register.
module ber_tlv_element_parser
    import btlv_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 4,
    parameter int INTEGER_WIDTH    = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tlast,   // end_of_buffer
    input  logic [1:0]   i_s_axis_tuser,   // [1:0] mode
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [119:0] o_m_axis_tdata,   // [7:0] value_byte, [15:8] element_tag,
                                           // [47:16] element_length,
                                           // [111:48] integer_value, [113:112] status
    output logic [1:0]   o_m_axis_tuser    // [1:0] result_kind
);

    localparam int LBW = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int IW  = INTEGER_WIDTH;

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_end;
    logic [1:0]     r_in_mode;

    t_phase         r_phase, n_phase;
    logic [1:0]     r_mode, n_mode;
    logic [7:0]     r_tag, n_tag;
    logic [LBW-1:0] r_lbl, n_lbl;
    logic [31:0]    r_lacc, n_lacc;
    logic [31:0]    r_cleft, n_cleft;
    logic [IW-1:0]  r_iacc, n_iacc;

    logic           r_out_valid;
    t_result        r_out, n_out;
    logic           n_emit;

    logic           proc_go;
    logic           len_done;
    logic [6:0]     len_count;
    logic [31:0]    len_shift;
    logic [IW-1:0]  iacc_base;
    logic [IW+7:0]  iacc_wide;
    logic           first_content;

    assign proc_go         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc_go;

    assign len_count     = r_in_byte[6:0] & LEN_COUNT_MASK;
    assign len_shift     = {r_lacc[23:0], r_in_byte};
    assign first_content = (r_cleft == r_lacc);
    assign iacc_base     = (first_content && r_in_byte[7]) ? {IW{1'b1}} : r_iacc;
    assign iacc_wide     = {iacc_base, r_in_byte};

    always_comb begin
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_tag    = r_tag;
        n_lbl    = r_lbl;
        n_lacc   = r_lacc;
        n_cleft  = r_cleft;
        n_iacc   = r_iacc;
        n_emit   = 1'b0;
        len_done = 1'b0;
        n_out    = '0;

        unique case (r_phase)
            PH_TAG: begin
                n_mode  = r_in_mode;
                n_tag   = r_in_byte;
                n_lbl   = '0;
                n_lacc  = '0;
                n_cleft = '0;
                n_iacc  = '0;
                if ((r_in_mode == MODE_INT && r_in_byte != TAG_INTEGER) ||
                    (r_in_mode == MODE_OCT && r_in_byte != TAG_OCTETS)) begin
                    n_emit       = 1'b1;
                    n_out.kind   = KIND_ERR;
                    n_out.status = ST_MALFORMED;
                    n_phase      = r_in_end ? PH_TAG : PH_DROP;
                end else if (r_in_end) begin
                    n_emit       = 1'b1;
                    n_out.kind   = KIND_ERR;
                    n_out.status = ST_TRUNC;
                    n_phase      = PH_TAG;
                end else begin
                    n_phase = PH_LEN_FIRST;
                end
            end
            PH_LEN_FIRST: begin
                if ((r_in_byte & LEN_LONG_FLAG) == 8'h00) begin
                    n_lacc   = {24'h0, r_in_byte};
                    len_done = 1'b1;
                end else if (len_count == 7'd0 ||
                             len_count > 7'(MAX_LENGTH_BYTES)) begin
                    n_emit       = 1'b1;
                    n_out.kind   = KIND_ERR;
                    n_out.status = ST_MALFORMED;
                    n_phase      = r_in_end ? PH_TAG : PH_DROP;
                end else begin
                    n_lbl  = LBW'(len_count);
                    n_lacc = '0;
                    if (r_in_end) begin
                        n_emit       = 1'b1;
                        n_out.kind   = KIND_ERR;
                        n_out.status = ST_TRUNC;
                        n_phase      = PH_TAG;
                    end else begin
                        n_phase = PH_LEN_LONG;
                    end
                end
            end
            PH_LEN_LONG: begin
                n_lacc = len_shift;
                n_lbl  = r_lbl - LBW'(1);
                if (r_lbl == LBW'(1)) begin
                    len_done = 1'b1;
                end else if (r_in_end) begin
                    n_emit       = 1'b1;
                    n_out.kind   = KIND_ERR;
                    n_out.status = ST_TRUNC;
                    n_phase      = PH_TAG;
                end
            end
            PH_CONTENT: begin
                if (r_mode == MODE_INT) begin
                    n_iacc = iacc_wide[IW-1:0];
                end
                n_cleft = r_cleft - 32'd1;
                if (r_cleft == 32'd1) begin
                    n_emit               = 1'b1;
                    n_out.kind           = KIND_DONE;
                    n_out.value_byte     = (r_mode == MODE_OCT) ? r_in_byte : 8'h00;
                    n_out.element_length = r_lacc;
                    n_out.integer_value  = (r_mode == MODE_INT) ?
                                           64'($signed(iacc_wide[IW-1:0])) : 64'h0;
                    n_out.status         = ST_OK;
                    n_phase              = PH_TAG;
                end else if (r_in_end) begin
                    n_emit       = 1'b1;
                    n_out.kind   = KIND_ERR;
                    n_out.status = ST_TRUNC;
                    n_phase      = PH_TAG;
                end else if (r_mode == MODE_OCT) begin
                    n_emit               = 1'b1;
                    n_out.kind           = KIND_BYTE;
                    n_out.value_byte     = r_in_byte;
                    n_out.element_length = r_lacc;
                    n_out.status         = ST_OK;
                end
            end
            PH_DROP: begin
                if (r_in_end) begin
                    n_phase = PH_TAG;
                end
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase

        if (len_done) begin
            n_cleft = n_lacc;
            n_iacc  = '0;
            if (n_lacc == 32'd0) begin
                n_emit = 1'b1;
                if (r_mode == MODE_INT) begin
                    n_out.kind   = KIND_ERR;
                    n_out.status = ST_TRUNC;
                    n_phase      = r_in_end ? PH_TAG : PH_DROP;
                end else begin
                    n_out.kind   = KIND_DONE;
                    n_out.status = ST_OK;
                    n_phase      = PH_TAG;
                end
            end else if (r_in_end) begin
                n_emit       = 1'b1;
                n_out.kind   = KIND_ERR;
                n_out.status = ST_TRUNC;
                n_phase      = PH_TAG;
            end else begin
                n_phase = PH_CONTENT;
            end
        end

        n_out.element_tag = n_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_TAG;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (proc_go) begin
                r_phase     <= n_phase;
                r_out_valid <= n_emit;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
            r_in_mode <= i_s_axis_tuser;
        end
        if (proc_go) begin
            r_mode  <= n_mode;
            r_tag   <= n_tag;
            r_lbl   <= n_lbl;
            r_lacc  <= n_lacc;
            r_cleft <= n_cleft;
            r_iacc  <= n_iacc;
            if (n_emit) begin
                r_out <= n_out;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {6'h00, r_out.status, r_out.integer_value,
                              r_out.element_length, r_out.element_tag, r_out.value_byte};

    a_err_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_ERR) |->
            ((r_out.status == ST_TRUNC || r_out.status == ST_MALFORMED) &&
             r_out.element_length == 32'd0 && r_out.integer_value == 64'h0))
        else $error("error result with bad status or nonzero fields");

    a_done_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind != KIND_ERR) |-> (r_out.status == ST_OK))
        else $error("non-error result without ok status");

    a_byte_mode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_BYTE) |->
            (r_mode == MODE_OCT && r_phase == PH_CONTENT))
        else $error("content byte result outside octet string content");

endmodule
